// ----- sv/tmp_pkg.sv -----
package tmp_pkg;

    localparam int DATA_W  = 32;
    localparam int ROOT_W  = 34;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int PROD_W  = 64;
    localparam int DIVA_W  = 64;
    localparam int LANES_A = 4;

    localparam logic [DATA_W-1:0] SAT_MAX = '1;

    typedef struct packed {
        logic [DATA_W-1:0] move_distance;
        logic [DATA_W-1:0] start_speed;
        logic [DATA_W-1:0] cruise_limit;
        logic [DATA_W-1:0] end_speed;
    } t_move_req;

    typedef struct packed {
        logic [DATA_W-1:0] accel_distance;
        logic [DATA_W-1:0] decel_distance;
        logic [DATA_W-1:0] peak_speed;
        logic [DATA_W-1:0] reachable_end_speed;
        logic              feasible;
        logic [DATA_W-1:0] travel_time;
    } t_move_plan;

    typedef struct packed {
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] peak;
        logic [DATA_W-1:0] reach;
        logic              feas;
        logic              swap;
        logic              up;
    } t_phase_side;

    typedef struct packed {
        logic [DATA_W-1:0] acc_d;
        logic [DATA_W-1:0] dec_d;
        logic [DATA_W-1:0] peak;
        logic [DATA_W-1:0] reach;
        logic              feas;
    } t_cruise_side;

    function automatic logic [DATA_W-1:0] sat32(input logic [PROD_W-1:0] v);
        logic [DATA_W-1:0] res;
        res = (v > PROD_W'(SAT_MAX)) ? SAT_MAX : v[DATA_W-1:0];
        return res;
    endfunction

endpackage

// ----- sv/tmp_stream_if.sv -----
interface tmp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tmp_sqrt.sv -----
module tmp_sqrt #(
    parameter int ROOT_W = 34,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W-1:0] r_valid;
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic              valid_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (g == 0) begin : g_first
            assign valid_in = i_valid;
            assign rad_in   = i_rad;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign side_in  = i_side;
        end else begin : g_next
            assign valid_in = r_valid[g-1];
            assign rad_in   = r_rad[g-1];
            assign rem_in   = r_rem[g-1];
            assign root_in  = r_root[g-1];
            assign side_in  = r_side[g-1];
        end

        assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g]  <= rad_in << 2;
                r_rem[g]  <= ge ? (cur - trial) : cur;
                r_root[g] <= {root_in[ROOT_W-2:0], ge};
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
endmodule

// ----- sv/tmp_div.sv -----
module tmp_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 33,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [LANES-1:0][DEN_W-1:0] i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][NUM_W-1:0] o_quot,
    output logic [SIDE_W-1:0]           o_side
);
    logic [NUM_W-1:0]                r_valid;
    logic [LANES-1:0][NUM_W-1:0]     r_numq [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]     r_rem  [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]     r_den  [NUM_W];
    logic [SIDE_W-1:0]               r_side [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic                        valid_in;
        logic [LANES-1:0][NUM_W-1:0] numq_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][DEN_W-1:0] den_in;
        logic [SIDE_W-1:0]           side_in;
        logic [LANES-1:0][NUM_W-1:0] n_numq;
        logic [LANES-1:0][DEN_W-1:0] n_rem;

        if (g == 0) begin : g_first
            assign valid_in = i_valid;
            assign numq_in  = i_num;
            assign rem_in   = '0;
            assign den_in   = i_den;
            assign side_in  = i_side;
        end else begin : g_next
            assign valid_in = r_valid[g-1];
            assign numq_in  = r_numq[g-1];
            assign rem_in   = r_rem[g-1];
            assign den_in   = r_den[g-1];
            assign side_in  = r_side[g-1];
        end

        always_comb begin
            logic [DEN_W:0] cur;
            logic           ge;
            for (int l = 0; l < LANES; l++) begin
                cur = {rem_in[l], numq_in[l][NUM_W-1]};
                ge  = (cur >= {1'b0, den_in[l]});
                n_rem[l]  = ge ? DEN_W'(cur - {1'b0, den_in[l]}) : cur[DEN_W-1:0];
                n_numq[l] = {numq_in[l][NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_numq[g] <= n_numq;
                r_rem[g]  <= n_rem;
                r_den[g]  <= den_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quot  = r_numq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];
endmodule

// ----- sv/trapezoid_move_planner.sv -----
// Trapezoidal move planner: takes one move request per cycle, while the
// output is not stalled, and returns one plan per request, in order. The
// bit-per-stage pipelines are a 34-stage square root, a 64-stage four-lane
// divider for the phase distances and ramp times, and a (32 + FRAC_BITS)-stage
// divider for the cruise time (FRAC_BITS = 16 gives Q16.16). The whole pipeline
// holds while a finished plan waits on the output. The acceleration register
// is written through the configuration channel, which is always ready; write
// it only while no move is in flight.
module trapezoid_move_planner #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tmp_stream_if.sink   i_cfg,
    tmp_stream_if.sink   i_req,
    tmp_stream_if.source o_res
);
    localparam int DW     = tmp_pkg::DATA_W;
    localparam int RW     = tmp_pkg::ROOT_W;
    localparam int PW     = tmp_pkg::PROD_W;
    localparam int AW     = tmp_pkg::DIVA_W;
    localparam int LA     = tmp_pkg::LANES_A;
    localparam int TIME_W = DW + FRAC_BITS;
    localparam int SQ_SW  = $bits(tmp_pkg::t_move_req);
    localparam int PA_SW  = $bits(tmp_pkg::t_phase_side);
    localparam int CR_SW  = $bits(tmp_pkg::t_cruise_side) + 2 * TIME_W;

    logic          adv;
    logic [DW-1:0] r_accel;
    logic [DW-1:0] accel_eff;

    assign adv         = !o_res.valid || o_res.ready;
    assign i_req.ready = adv;
    assign i_cfg.ready = 1'b1;
    assign accel_eff   = (r_accel == '0) ? DW'(1) : r_accel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= DW'(1) << FRAC_BITS;
        end else if (i_cfg.valid) begin
            r_accel <= i_cfg.data;
        end
    end

    // square and product
    logic                r_s0_valid;
    tmp_pkg::t_move_req  r_s0_set;
    logic [PW-1:0]       r_s0_ss;
    logic [PW-1:0]       r_s0_ad;
    tmp_pkg::t_move_req  n_s0_set;

    always_comb begin
        n_s0_set = i_req.data;
        if (i_req.data.end_speed > i_req.data.cruise_limit) begin
            n_s0_set.end_speed = i_req.data.cruise_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_set <= n_s0_set;
            r_s0_ss  <= PW'(i_req.data.start_speed) * PW'(i_req.data.start_speed);
            r_s0_ad  <= PW'(accel_eff) * PW'(i_req.data.move_distance);
        end
    end

    // radicand
    logic                r_s1_valid;
    tmp_pkg::t_move_req  r_s1_set;
    logic [2*RW-1:0]     r_s1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_set <= r_s0_set;
            r_s1_rad <= (2*RW)'(r_s0_ss) + ((2*RW)'(r_s0_ad) << 1);
        end
    end

    logic               sq_valid;
    logic [RW-1:0]      sq_root;
    tmp_pkg::t_move_req sq_set;

    tmp_sqrt #(
        .ROOT_W (RW),
        .SIDE_W (SQ_SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s1_valid),
        .i_rad   (r_s1_rad),
        .i_side  (r_s1_set),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_set)
    );

    // speed change and needed change
    logic               r_p1_valid;
    tmp_pkg::t_move_req r_p1_set;
    logic [RW-1:0]      r_p1_m;
    logic [DW-1:0]      r_p1_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_set   <= sq_set;
            r_p1_m     <= sq_root - RW'(sq_set.start_speed);
            r_p1_delta <= (sq_set.end_speed >= sq_set.start_speed)
                        ? sq_set.end_speed - sq_set.start_speed
                        : sq_set.start_speed - sq_set.end_speed;
        end
    end

    // profile shape
    logic                 r_p2_valid;
    tmp_pkg::t_phase_side r_p2_side;
    logic [DW-1:0]        r_p2_s;
    logic [DW-1:0]        r_p2_lo;
    logic [DW-1:0]        r_p2_hi;
    tmp_pkg::t_phase_side n_p2_side;
    logic [RW:0]          top_sum;
    logic [RW-1:0]        top;
    logic [RW:0]          up_sum;
    logic [DW-1:0]        p2_s;
    logic [DW-1:0]        p2_e;
    logic [DW-1:0]        p2_c;

    assign p2_s    = r_p1_set.start_speed;
    assign p2_e    = r_p1_set.end_speed;
    assign p2_c    = r_p1_set.cruise_limit;
    assign top_sum = (RW+1)'(p2_s) + (RW+1)'(p2_e) + (RW+1)'(r_p1_m);
    assign top     = top_sum[RW:1];
    assign up_sum  = (RW+1)'(p2_s) + (RW+1)'(r_p1_m);

    always_comb begin
        n_p2_side.span = r_p1_set.move_distance;
        n_p2_side.swap = (p2_s > p2_e);
        n_p2_side.up   = (p2_s < p2_e);
        n_p2_side.feas = (r_p1_m >= RW'(r_p1_delta));
        priority if (n_p2_side.feas) begin
            n_p2_side.peak  = (top < RW'(p2_c)) ? top[DW-1:0] : p2_c;
            n_p2_side.reach = p2_e;
        end else if (n_p2_side.up) begin
            n_p2_side.peak  = tmp_pkg::sat32(PW'(up_sum));
            n_p2_side.reach = n_p2_side.peak;
        end else begin
            n_p2_side.peak  = p2_s;
            n_p2_side.reach = p2_s - r_p1_m[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_side <= n_p2_side;
            r_p2_s    <= p2_s;
            r_p2_lo   <= (p2_s < p2_e) ? p2_s : p2_e;
            r_p2_hi   <= (p2_s < p2_e) ? p2_e : p2_s;
        end
    end

    // squares and ramp speed changes
    logic                 r_p3_valid;
    tmp_pkg::t_phase_side r_p3_side;
    logic [PW-1:0]        r_p3_lo2;
    logic [PW-1:0]        r_p3_pk2;
    logic [PW-1:0]        r_p3_hi2;
    logic [DW-1:0]        r_p3_ta;
    logic [DW-1:0]        r_p3_td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (adv) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_side <= r_p2_side;
            r_p3_lo2  <= PW'(r_p2_lo) * PW'(r_p2_lo);
            r_p3_pk2  <= PW'(r_p2_side.peak) * PW'(r_p2_side.peak);
            r_p3_hi2  <= PW'(r_p2_hi) * PW'(r_p2_hi);
            r_p3_ta   <= (r_p2_side.peak >= r_p2_s) ? r_p2_side.peak - r_p2_s
                                                    : r_p2_s - r_p2_side.peak;
            r_p3_td   <= (r_p2_side.reach >= r_p2_side.peak)
                       ? r_p2_side.reach - r_p2_side.peak
                       : r_p2_side.peak - r_p2_side.reach;
        end
    end

    // divider numerators
    logic                     r_p4_valid;
    tmp_pkg::t_phase_side     r_p4_side;
    logic [LA-1:0][AW-1:0]    r_p4_num;
    logic [LA-1:0][DW:0]      diva_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (adv) begin
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4_side   <= r_p3_side;
            r_p4_num[0] <= (r_p3_pk2 >= r_p3_lo2) ? r_p3_pk2 - r_p3_lo2
                                                  : r_p3_lo2 - r_p3_pk2;
            r_p4_num[1] <= (r_p3_hi2 >= r_p3_pk2) ? r_p3_hi2 - r_p3_pk2
                                                  : r_p3_pk2 - r_p3_hi2;
            r_p4_num[2] <= AW'(r_p3_ta) << FRAC_BITS;
            r_p4_num[3] <= AW'(r_p3_td) << FRAC_BITS;
        end
    end

    assign diva_den[0] = {accel_eff, 1'b0};
    assign diva_den[1] = {accel_eff, 1'b0};
    assign diva_den[2] = {1'b0, accel_eff};
    assign diva_den[3] = {1'b0, accel_eff};

    logic                  da_valid;
    logic [LA-1:0][AW-1:0] da_quot;
    tmp_pkg::t_phase_side  da_side;

    tmp_div #(
        .NUM_W  (AW),
        .DEN_W  (DW + 1),
        .LANES  (LA),
        .SIDE_W (PA_SW)
    ) u_div_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p4_valid),
        .i_num   (r_p4_num),
        .i_den   (diva_den),
        .i_side  (r_p4_side),
        .o_valid (da_valid),
        .o_quot  (da_quot),
        .o_side  (da_side)
    );

    // phase distances and cruise distance
    logic                  r_q1_valid;
    tmp_pkg::t_cruise_side r_q1_side;
    logic [TIME_W-1:0]     r_q1_tacc;
    logic [TIME_W-1:0]     r_q1_tdec;
    logic [TIME_W-1:0]     r_q1_num;
    tmp_pkg::t_cruise_side n_q1_side;
    logic [DW-1:0]         q0_sat;
    logic [DW-1:0]         q1_sat;
    logic [DW:0]           used;
    logic [DW-1:0]         cdist;

    assign q0_sat = tmp_pkg::sat32(da_quot[0]);
    assign q1_sat = tmp_pkg::sat32(da_quot[1]);

    always_comb begin
        n_q1_side.peak  = da_side.peak;
        n_q1_side.reach = da_side.reach;
        n_q1_side.feas  = da_side.feas;
        priority if (da_side.feas && da_side.swap) begin
            n_q1_side.acc_d = q1_sat;
            n_q1_side.dec_d = q0_sat;
        end else if (da_side.feas) begin
            n_q1_side.acc_d = q0_sat;
            n_q1_side.dec_d = q1_sat;
        end else if (da_side.up) begin
            n_q1_side.acc_d = da_side.span;
            n_q1_side.dec_d = '0;
        end else begin
            n_q1_side.acc_d = '0;
            n_q1_side.dec_d = da_side.span;
        end
    end

    assign used  = (DW+1)'(n_q1_side.acc_d) + (DW+1)'(n_q1_side.dec_d);
    assign cdist = ((DW+1)'(da_side.span) > used) ? DW'((DW+1)'(da_side.span) - used) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
        end else if (adv) begin
            r_q1_valid <= da_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q1_side <= n_q1_side;
            r_q1_tacc <= da_quot[2][TIME_W-1:0];
            r_q1_tdec <= da_quot[3][TIME_W-1:0];
            r_q1_num  <= TIME_W'(cdist) << FRAC_BITS;
        end
    end

    logic                  db_valid;
    logic [TIME_W-1:0]     db_quot;
    tmp_pkg::t_cruise_side db_side;
    logic [TIME_W-1:0]     db_tacc;
    logic [TIME_W-1:0]     db_tdec;

    tmp_div #(
        .NUM_W  (TIME_W),
        .DEN_W  (DW),
        .LANES  (1),
        .SIDE_W (CR_SW)
    ) u_div_cruise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_q1_valid),
        .i_num   (r_q1_num),
        .i_den   (r_q1_side.peak),
        .i_side  ({r_q1_side, r_q1_tacc, r_q1_tdec}),
        .o_valid (db_valid),
        .o_quot  (db_quot),
        .o_side  ({db_side, db_tacc, db_tdec})
    );

    // total time and output register
    logic               r_out_valid;
    tmp_pkg::t_move_plan r_out;
    logic [TIME_W-1:0]  tcru;
    logic [TIME_W+1:0]  total;

    assign tcru  = (db_side.peak == '0) ? '0 : db_quot;
    assign total = (TIME_W+2)'(db_tacc) + (TIME_W+2)'(db_tdec) + (TIME_W+2)'(tcru);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= db_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.accel_distance      <= db_side.acc_d;
            r_out.decel_distance      <= db_side.dec_d;
            r_out.peak_speed          <= db_side.peak;
            r_out.reachable_end_speed <= db_side.reach;
            r_out.feasible            <= db_side.feas;
            r_out.travel_time         <= tmp_pkg::sat32(PW'(total));
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");

    a_reach_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.reachable_end_speed <= o_res.data.peak_speed))
        else $error("reachable end speed above peak");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.feasible)
            |-> (o_res.data.accel_distance == '0 || o_res.data.decel_distance == '0))
        else $error("infeasible move with two phases");
`endif
endmodule

// ----- bench/trapezoid_move_planner_test.sv -----
module trapezoid_move_planner_test;

    localparam int FRAC = 16;
    localparam int LATENCY = 138 + FRAC;
    localparam int NUM_RANDOM = 1400;
    localparam longint LIMIT = 64'd3_000_000;
    localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

    class plan_scoreboard;
        logic [31:0]         accel;
        tmp_pkg::t_move_plan pending[$];
        int                  mismatches;

        function new();
            accel = 32'h0001_0000;
            mismatches = 0;
        endfunction

        function logic [63:0] sat(input logic [63:0] v);
            return (v > MASK32) ? MASK32 : v;
        endfunction

        function logic [63:0] absd(input logic [63:0] x, input logic [63:0] y);
            return (x >= y) ? x - y : y - x;
        endfunction

        function logic [63:0] root(input logic [127:0] x);
            logic [63:0]  r;
            logic [63:0]  cand;
            logic [127:0] sq;
            r = 0;
            for (int b = 33; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                sq = 128'(cand) * 128'(cand);
                if (sq <= x) begin
                    r = cand;
                end
            end
            return r;
        endfunction

        function logic [63:0] ramp_dist(input logic [63:0] v0, input logic [63:0] v1,
                                        input logic [63:0] a);
            return sat(absd(v1 * v1, v0 * v0) / (a * 2));
        endfunction

        function void note_move(input tmp_pkg::t_move_req q);
            logic [63:0]  d, s, c, e, a, m, delta, lo, hi, top, tmp;
            logic [63:0]  acc_d, dec_d, peak, reach, feas, t_acc, t_dec, t_cru;
            logic [63:0]  used, cdist, total;
            logic [127:0] rad;
            tmp_pkg::t_move_plan p;
            d = q.move_distance;
            s = q.start_speed;
            c = q.cruise_limit;
            e = q.end_speed;
            a = (accel == 0) ? 64'd1 : 64'(accel);
            if (e > c) begin
                e = c;
            end
            delta = absd(e, s);
            rad = 128'(s) * 128'(s) + 128'(a * d) * 2;
            m = root(rad) - s;
            if (m >= delta) begin
                lo = (s < e) ? s : e;
                hi = (s < e) ? e : s;
                top = (s + e + m) >> 1;
                peak = (top < c) ? top : c;
                acc_d = ramp_dist(lo, peak, a);
                dec_d = ramp_dist(peak, hi, a);
                if (s > e) begin
                    tmp = acc_d;
                    acc_d = dec_d;
                    dec_d = tmp;
                end
                reach = e;
                feas = 1;
            end else if (s < e) begin
                peak = sat(s + m);
                reach = peak;
                acc_d = d;
                dec_d = 0;
                feas = 0;
            end else begin
                peak = s;
                reach = s - m;
                acc_d = 0;
                dec_d = d;
                feas = 0;
            end
            t_acc = (absd(peak, s) << FRAC) / a;
            t_dec = (absd(reach, peak) << FRAC) / a;
            used = acc_d + dec_d;
            cdist = (d > used) ? d - used : 0;
            t_cru = (peak != 0) ? (cdist << FRAC) / peak : 0;
            total = sat(t_acc + t_dec + t_cru);
            p.accel_distance = acc_d[31:0];
            p.decel_distance = dec_d[31:0];
            p.peak_speed = peak[31:0];
            p.reachable_end_speed = reach[31:0];
            p.feasible = feas[0];
            p.travel_time = total[31:0];
            pending.push_back(p);
        endfunction

        function void check_plan(input tmp_pkg::t_move_plan got);
            tmp_pkg::t_move_plan want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected plan %h", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("plan mismatch: expected %h actual %h", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tmp_stream_if #(.T(logic [31:0]))         cfg_if ();
    tmp_stream_if #(.T(tmp_pkg::t_move_req))  req_if ();
    tmp_stream_if #(.T(tmp_pkg::t_move_plan)) res_if ();

    trapezoid_move_planner #(.FRAC_BITS(FRAC)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if.sink),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    plan_scoreboard board;
    int     send_idle;
    int     recv_idle;
    longint cycles;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_plan(res_if.data);
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            board.note_move(req_if.data);
        end
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            board.accel = cfg_if.data;
        end
        res_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_accel(input logic [31:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_move(input tmp_pkg::t_move_req q);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_field();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000);
            2: return $urandom_range(32'h0400_0000);
            3: return 32'hFFFF_FFFF - $urandom_range(255);
            4: return $urandom_range(255);
            default: return 32'h0001_0000 << $urandom_range(15);
        endcase
    endfunction

    function automatic logic [31:0] pick_accel();
        case ($urandom_range(4))
            0: return $urandom_range(1, 255);
            1: return $urandom;
            default: return 32'h0001_0000 << $urandom_range(12);
        endcase
    endfunction

    task automatic random_moves(input int n);
        tmp_pkg::t_move_req q;
        for (int i = 0; i < n; i++) begin
            q.move_distance = pick_field();
            q.start_speed   = pick_field();
            q.cruise_limit  = pick_field();
            q.end_speed     = ($urandom_range(3) == 0) ? q.start_speed : pick_field();
            send_move(q);
        end
    endtask

    initial begin
        tmp_pkg::t_move_req q;
        logic [31:0] edges[5];
        board = new();
        i_rst_n = 1'b0;
        send_idle = 6;
        recv_idle = 76;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        edges = '{32'h0, 32'h1, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < 20; i++) begin
            q.move_distance = edges[i % 5];
            q.start_speed   = edges[(i / 5 + i) % 5];
            q.cruise_limit  = edges[(i * 3 + 1) % 5];
            q.end_speed     = edges[(i * 2 + 2) % 5];
            send_move(q);
        end
        send_move('{32'h0064_0000, 32'h0005_0000, 32'h0002_0000, 32'h0001_0000});
        send_move('{32'h0000_0010, 32'h0, 32'h0064_0000, 32'h0064_0000});
        send_move('{32'h0000_0010, 32'h0064_0000, 32'h0064_0000, 32'h0});
        drain();

        write_accel(32'h0);
        random_moves(40);
        drain();
        write_accel(32'hFFFF_FFFF);
        random_moves(40);
        drain();
        write_accel(32'h1);
        random_moves(40);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                send_idle = 76;
                recv_idle = 6;
            end else if (ph == 8) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_accel(pick_accel());
            random_moves(100);
            drain();
        end
        write_accel(32'h0001_0000);
        random_moves(80);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
